>>> sv/dsc_pkg.sv
// Shared types, signature tables and constants for the disc signature classifier.
// Used by every module of the block; it depends on nothing else.
package dsc_pkg;

  // Default probe window in bytes.
  localparam int unsigned PROBE_BYTES_DEF = 65536;

  // Configuration port geometry: one 40-bit register at byte address 0.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned FILE_SIZE_W = 40;
  localparam logic [FILE_SIZE_W-1:0] SIZE_LIMIT = 40'd838860800;

  // System codes as carried in the result.
  localparam logic [3:0] SYS_NONE    = 4'd0;
  localparam logic [3:0] SYS_MAGIC_A = 4'd1;
  localparam logic [3:0] SYS_MAGIC_B = 4'd2;
  localparam logic [3:0] SYS_TEXT_A  = 4'd3;
  localparam logic [3:0] SYS_TEXT_B  = 4'd4;
  localparam logic [3:0] SYS_TEXT_C  = 4'd5;
  localparam logic [3:0] SYS_TEXT_D  = 4'd6;
  localparam logic [3:0] SYS_TEXT_E  = 4'd7;
  localparam logic [3:0] SYS_TEXT_F  = 4'd8;

  // Signature table, in priority order.
  localparam int unsigned NUM_ENTRIES = 11;
  localparam int unsigned POOL_LEN = 85;
  localparam int unsigned POOL_W = 7;

  localparam logic [15:0] SIG_OFF [NUM_ENTRIES] = '{
    16'h001C, 16'h0018, 16'h0218, 16'h0070, 16'h0010, 16'h0010,
    16'h0010, 16'h8008, 16'h8008, 16'h9320, 16'h24F8
  };
  localparam logic [3:0] SIG_LEN [NUM_ENTRIES] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd15, 4'd14, 4'd15, 4'd8, 4'd11, 4'd11, 4'd14
  };
  localparam logic [POOL_W-1:0] SIG_POOL [NUM_ENTRIES] = '{
    7'd0, 7'd4, 7'd4, 7'd4, 7'd8, 7'd23, 7'd37, 7'd52, 7'd60, 7'd60, 7'd71
  };
  localparam logic [3:0] SIG_CODE [NUM_ENTRIES] = '{
    SYS_MAGIC_A, SYS_MAGIC_B, SYS_MAGIC_B, SYS_MAGIC_B, SYS_TEXT_A, SYS_TEXT_B,
    SYS_TEXT_C, SYS_TEXT_D, SYS_TEXT_E, SYS_TEXT_E, SYS_TEXT_F
  };

  // All signature bytes back to back; entries point into this pool.
  localparam logic [7:0] PATTERN_POOL [POOL_LEN] = '{
    8'hC2, 8'h33, 8'h9F, 8'h3D,
    8'h5D, 8'h1C, 8'h9E, 8'hA3,
    8'h53, 8'h45, 8'h47, 8'h41, 8'h20, 8'h53, 8'h45, 8'h47, 8'h41, 8'h4B,
    8'h41, 8'h54, 8'h41, 8'h4E, 8'h41,
    8'h53, 8'h45, 8'h47, 8'h41, 8'h44, 8'h49, 8'h53, 8'h43, 8'h53, 8'h59,
    8'h53, 8'h54, 8'h45, 8'h4D,
    8'h53, 8'h45, 8'h47, 8'h41, 8'h20, 8'h53, 8'h45, 8'h47, 8'h41, 8'h53,
    8'h41, 8'h54, 8'h55, 8'h52, 8'h4E,
    8'h50, 8'h53, 8'h50, 8'h20, 8'h47, 8'h41, 8'h4D, 8'h45,
    8'h50, 8'h4C, 8'h41, 8'h59, 8'h53, 8'h54, 8'h41, 8'h54, 8'h49, 8'h4F, 8'h4E,
    8'h53, 8'h6F, 8'h6E, 8'h79, 8'h20, 8'h43, 8'h6F, 8'h6D, 8'h70, 8'h75,
    8'h74, 8'h65, 8'h72, 8'h20
  };

  // Serial byte store layout: short id, then the two longer serial fields.
  localparam int unsigned STORE_DEPTH = 27;
  localparam int unsigned STORE_AW = 5;
  localparam int unsigned ID_LEN = 6;
  localparam int unsigned SAT_AT = 32'h20;
  localparam int unsigned SAT_LEN = 10;
  localparam int unsigned CD_AT = 32'h183;
  localparam int unsigned CD_LEN = 11;
  localparam int unsigned SAT_BASE = ID_LEN;
  localparam int unsigned CD_BASE = ID_LEN + SAT_LEN;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // Channel payloads.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } dsc_in_t;

  typedef struct packed {
    logic [3:0] system_code;
    logic       detected;
    logic [7:0] serial_char;
    logic       is_serial;
    logic       end_of_run;
  } dsc_out_t;

  // Decision taken on the final byte of a run.
  typedef struct packed {
    logic                valid;
    logic [3:0]          code;
    logic                detected;
    logic [STORE_AW-1:0] rd_start;
    logic [3:0]          rd_count;
  } dsc_verdict_t;

  // Write request into the serial byte store.
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } dsc_wr_t;

endpackage

>>> sv/dsc_sig_match.sv
// Byte position tracking, signature comparison and the end-of-run decision.
// Depends on dsc_pkg for the signature tables and the shared structs.
module dsc_sig_match #(
  parameter int unsigned PROBE_BYTES = dsc_pkg::PROBE_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  dsc_pkg::dsc_in_t      in_data_i,
  input  logic                  remap_en_i,
  output dsc_pkg::dsc_wr_t      wr_o,
  output dsc_pkg::dsc_verdict_t verdict_o
);
  import dsc_pkg::*;

  localparam int unsigned PW = $clog2(PROBE_BYTES + 1);

  logic [PW-1:0]          pos_q, pos_d;
  logic [NUM_ENTRIES-1:0] alive_q, alive_d;
  logic                   id_ok_q, id_ok_d;

  logic                   proc;
  logic [PW-1:0]          size;
  logic [NUM_ENTRIES-1:0] miss;
  logic [NUM_ENTRIES-1:0] alive_upd;
  logic                   id_ok_upd;
  logic                   bad_char;
  logic                   found;
  logic [3:0]             raw_code;
  logic [7:0]             b;

  assign b    = in_data_i.data_byte;
  assign proc = pos_q < PW'(PROBE_BYTES);
  assign size = proc ? pos_q + PW'(1) : pos_q;

  // Compare the byte against every signature whose window covers this position.
  always_comb begin
    logic [PW-1:0]     diff;
    logic [POOL_W-1:0] pidx;
    logic              in_win;
    miss = '0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      in_win = (pos_q >= PW'(SIG_OFF[e])) &&
               (pos_q < PW'(SIG_OFF[e]) + PW'(SIG_LEN[e]));
      diff = pos_q - PW'(SIG_OFF[e]);
      pidx = SIG_POOL[e] + diff[POOL_W-1:0];
      if (in_win && (pidx < POOL_W'(POOL_LEN))) begin
        miss[e] = PATTERN_POOL[pidx] != b;
      end
    end
  end

  assign alive_upd = proc ? (alive_q & ~miss) : alive_q;
  assign bad_char  = (b < PRINT_LO) || (b > PRINT_HI);
  assign id_ok_upd = id_ok_q && !(proc && (pos_q < PW'(ID_LEN)) && bad_char);

  // First surviving entry that the stream covers completely wins.
  always_comb begin
    found    = 1'b0;
    raw_code = SYS_NONE;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      if (alive_upd[e] && (size >= PW'(SIG_OFF[e]) + PW'(SIG_LEN[e]))) begin
        found    = 1'b1;
        raw_code = SIG_CODE[e];
      end
    end
  end

  // Verdict and the range of serial bytes to read back.
  always_comb begin
    verdict_o.valid    = accept_i && in_data_i.last_byte;
    verdict_o.detected = found;
    verdict_o.code     = (raw_code == SYS_TEXT_E && remap_en_i) ? SYS_TEXT_F : raw_code;
    verdict_o.rd_start = '0;
    verdict_o.rd_count = '0;
    case (raw_code) inside
      SYS_MAGIC_A, SYS_MAGIC_B: begin
        if (id_ok_upd && (size >= PW'(ID_LEN))) begin
          verdict_o.rd_start = '0;
          verdict_o.rd_count = 4'(ID_LEN);
        end
      end
      SYS_TEXT_C: begin
        if (size >= PW'(SAT_AT + SAT_LEN)) begin
          verdict_o.rd_start = STORE_AW'(SAT_BASE);
          verdict_o.rd_count = 4'(SAT_LEN);
        end
      end
      SYS_TEXT_B: begin
        if (size >= PW'(CD_AT + CD_LEN)) begin
          verdict_o.rd_start = STORE_AW'(CD_BASE);
          verdict_o.rd_count = 4'(CD_LEN);
        end
      end
      default: begin
        verdict_o.rd_count = '0;
      end
    endcase
  end

  // Capture the id and serial fields into the byte store.
  always_comb begin
    wr_o.data = b;
    wr_o.en   = 1'b0;
    wr_o.addr = '0;
    if (pos_q < PW'(ID_LEN)) begin
      wr_o.en   = 1'b1;
      wr_o.addr = STORE_AW'(pos_q);
    end else if ((pos_q >= PW'(SAT_AT)) && (pos_q < PW'(SAT_AT + SAT_LEN))) begin
      wr_o.en   = 1'b1;
      wr_o.addr = STORE_AW'(pos_q - PW'(SAT_AT)) + STORE_AW'(SAT_BASE);
    end else if ((pos_q >= PW'(CD_AT)) && (pos_q < PW'(CD_AT + CD_LEN))) begin
      wr_o.en   = 1'b1;
      wr_o.addr = STORE_AW'(pos_q - PW'(CD_AT)) + STORE_AW'(CD_BASE);
    end
    wr_o.en = wr_o.en && accept_i && proc;
  end

  // Run state advances on each transfer and restarts after the final byte.
  always_comb begin
    pos_d   = pos_q;
    alive_d = alive_q;
    id_ok_d = id_ok_q;
    if (accept_i) begin
      if (in_data_i.last_byte) begin
        pos_d   = '0;
        alive_d = '1;
        id_ok_d = 1'b1;
      end else begin
        pos_d   = size;
        alive_d = alive_upd;
        id_ok_d = id_ok_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      alive_q <= '1;
      id_ok_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      alive_q <= alive_d;
      id_ok_q <= id_ok_d;
    end
  end

endmodule

>>> sv/dsc_serial_ram.sv
// Serial byte store: one write port, one read port with registered read data.
// Depends on dsc_pkg for the store depth and address width.
module dsc_serial_ram (
  input  logic                         clk_i,
  input  dsc_pkg::dsc_wr_t             wr_i,
  input  logic                         re_i,
  input  logic [dsc_pkg::STORE_AW-1:0] raddr_i,
  output logic [7:0]                   rdata_o
);
  import dsc_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dsc_emit.sv
// Result sequencer: verdict, serial byte readout and the output register.
// Depends on dsc_pkg for the verdict and result structs.
module dsc_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dsc_pkg::dsc_verdict_t        verdict_i,
  input  logic [7:0]                   rdata_i,
  output logic                         re_o,
  output logic [dsc_pkg::STORE_AW-1:0] raddr_o,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dsc_pkg::dsc_out_t            out_data_o
);
  import dsc_pkg::*;

  // Readout job.
  logic [STORE_AW-1:0] rd_addr_q, rd_addr_d;
  logic [3:0]          rd_left_q, rd_left_d;
  logic [3:0]          job_code_q, job_code_d;

  // Stage one: the result waiting on the read data register.
  logic       s1_valid_q, s1_valid_d;
  logic       s1_ser_q, s1_ser_d;
  logic       s1_eor_q, s1_eor_d;
  logic [3:0] s1_code_q, s1_code_d;
  logic       s1_det_q, s1_det_d;

  // Output register.
  logic     out_valid_q;
  dsc_out_t out_q;

  logic adv_out, s1_free, busy;

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || adv_out;
  assign busy       = rd_left_q != '0;
  assign re_o       = busy && s1_free;
  assign raddr_o    = rd_addr_q;
  assign in_stall_o = busy || !s1_free;

  // Load the verdict on the final byte, then one serial read per free slot.
  always_comb begin
    rd_addr_d  = rd_addr_q;
    rd_left_d  = rd_left_q;
    job_code_d = job_code_q;
    s1_valid_d = s1_valid_q;
    s1_ser_d   = s1_ser_q;
    s1_eor_d   = s1_eor_q;
    s1_code_d  = s1_code_q;
    s1_det_d   = s1_det_q;
    if (verdict_i.valid) begin
      s1_valid_d = 1'b1;
      s1_ser_d   = 1'b0;
      s1_eor_d   = verdict_i.rd_count == '0;
      s1_code_d  = verdict_i.code;
      s1_det_d   = verdict_i.detected;
      job_code_d = verdict_i.code;
      rd_addr_d  = verdict_i.rd_start;
      rd_left_d  = verdict_i.rd_count;
    end else if (re_o) begin
      s1_valid_d = 1'b1;
      s1_ser_d   = 1'b1;
      s1_eor_d   = rd_left_q == 4'd1;
      s1_code_d  = job_code_q;
      s1_det_d   = 1'b1;
      rd_addr_d  = rd_addr_q + STORE_AW'(1);
      rd_left_d  = rd_left_q - 4'd1;
    end else if (s1_valid_q && adv_out) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_left_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_left_q  <= rd_left_d;
      s1_valid_q <= s1_valid_d;
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    job_code_q <= job_code_d;
    s1_ser_q   <= s1_ser_d;
    s1_eor_q   <= s1_eor_d;
    s1_code_q  <= s1_code_d;
    s1_det_q   <= s1_det_d;
    if (adv_out && s1_valid_q) begin
      out_q.system_code <= s1_code_q;
      out_q.detected    <= s1_det_q;
      out_q.serial_char <= s1_ser_q ? rdata_i : 8'h00;
      out_q.is_serial   <= s1_ser_q;
      out_q.end_of_run  <= s1_eor_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/disc_signature_classifier_top.sv
// Top level of the disc signature classifier: configuration port and block wiring.
// Depends on dsc_pkg, dsc_sig_match, dsc_serial_ram and dsc_emit.

// The block takes an image prefix one byte per cycle while in_stall is low,
// and compares each byte against the eleven fixed-offset signatures as it passes.
// On the byte marked last it produces a verdict, followed by up to eleven serial
// bytes, one result per cycle while the output is not stalled; these come out of
// the single read port of the serial byte store, so the input is stalled while
// the serial bytes (0, 6, 10 or 11) are read, before the next image may start.
// The result sits in an output register behind a one-entry stage, so input
// transfers continue while a single result waits in the output register. file_size
// sits at byte address 0 of the 64-bit configuration port; the user must write it
// only between images, and the block itself does not enforce this.
module disc_signature_classifier_top #(
  parameter int unsigned PROBE_BYTES = dsc_pkg::PROBE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dsc_pkg::dsc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dsc_pkg::dsc_out_t              out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dsc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dsc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dsc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import dsc_pkg::*;

  logic [FILE_SIZE_W-1:0] file_size_q;
  logic                   remap_en;
  logic                   accept;
  dsc_wr_t                wr;
  dsc_verdict_t           verdict;
  logic                   re;
  logic [STORE_AW-1:0]    raddr;
  logic [7:0]             rdata;

  // Configuration register; the only register decodes every address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      file_size_q <= pwdata[FILE_SIZE_W-1:0];
    end
  end

  assign pready   = 1'b1;
  assign prdata   = CFG_DATA_W'(file_size_q);
  assign remap_en = (file_size_q != '0) && (file_size_q <= SIZE_LIMIT);
  assign accept   = in_valid_i && !in_stall_o;

  dsc_sig_match #(
    .PROBE_BYTES (PROBE_BYTES)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .remap_en_i (remap_en),
    .wr_o       (wr),
    .verdict_o  (verdict)
  );

  dsc_serial_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dsc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .verdict_i   (verdict),
    .rdata_i     (rdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/dsc_port_checker.sv
// Port-level checks for the disc signature classifier, bound to the top level.
// Depends on dsc_pkg for the payload structs and system codes.
module dsc_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input dsc_pkg::dsc_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dsc_pkg::dsc_out_t out_data_o
);
  import dsc_pkg::*;

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A final byte transfer is followed by a valid result, after stage one and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_byte |-> ##2 out_valid_o)
    else $error("no result after final byte");

  // Serial bytes only follow a detection of a code that carries a serial.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_serial |->
      out_data_o.detected &&
      (out_data_o.system_code == SYS_MAGIC_A || out_data_o.system_code == SYS_MAGIC_B ||
       out_data_o.system_code == SYS_TEXT_B || out_data_o.system_code == SYS_TEXT_C))
    else $error("serial byte with wrong verdict fields");

  // A verdict without a match is code zero and closes the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_serial && !out_data_o.detected |->
      out_data_o.system_code == SYS_NONE && out_data_o.end_of_run &&
      out_data_o.serial_char == 8'h00)
    else $error("bad empty verdict");

endmodule

bind disc_signature_classifier_top dsc_port_checker u_port_checker (.*);
